// ===== hdl/slwb_pkg.sv =====
`timescale 1ns / 1ps

package slwb_pkg;

    localparam int MAX_LINE_LENGTH = 4096;
    localparam int CNT_MAX         = 4095;
    // char_position stops at the smaller of the two limits
    localparam int POS_LIMIT = (MAX_LINE_LENGTH - 1 < CNT_MAX) ? MAX_LINE_LENGTH - 1 : CNT_MAX;

    localparam int COL_W = 16;
    localparam int POS_W = 12;
    localparam int CNT_W = 12;
    localparam int TAB_W = 5;

    // remainder unit retires one dividend bit per cycle
    localparam int DIV_STEPS = COL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [COL_W-1:0] MAX_WIDTH_RESET = 16'd80;
    localparam logic [TAB_W-1:0] TAB_WIDTH_RESET = 5'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    localparam logic [1:0] CFG_MAX_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TAB_WIDTH      = 2'd1;

    localparam logic KIND_BREAK = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic             result_kind;
        logic [COL_W-1:0] result_value;
        logic [CNT_W-1:0] break_number;
        logic             run_end;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic need_mod;
        logic out_empty;
    } t_dp_status;

endpackage

// ===== hdl/soft_line_wrap_breaks.sv =====
`timescale 1ns / 1ps
// An accepted character is latched; a tab with nonzero tab width then goes through the
//   bit-serial remainder unit, which takes one column bit per cycle. The line state and
//   results update when the output buffer is empty; only then is the next input taken.
// A character whose results are still queued does not block the next accept.
// Reset (i_rst_n low, synchronous): line state cleared, max_line_width 80, tab_width 4.
module soft_line_wrap_breaks (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  slwb_pkg::t_in_word         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output slwb_pkg::t_out_word        o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [slwb_pkg::COL_W-1:0] i_cfg_data
);

    logic [slwb_pkg::COL_W-1:0] r_max_width;
    logic [slwb_pkg::TAB_W-1:0] r_tab_width;
    slwb_pkg::t_dp_cmd          dp_cmd;
    slwb_pkg::t_dp_status       dp_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= slwb_pkg::MAX_WIDTH_RESET;
            r_tab_width <= slwb_pkg::TAB_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == slwb_pkg::CFG_MAX_LINE_WIDTH) begin
                r_max_width <= i_cfg_data;
            end else if (i_cfg_index == slwb_pkg::CFG_TAB_WIDTH) begin
                r_tab_width <= i_cfg_data[slwb_pkg::TAB_W-1:0];
            end
        end
    end

    slwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    slwb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_max_width (r_max_width),
        .i_tab_width (r_tab_width),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/slwb_ctrl.sv =====
`timescale 1ns / 1ps

module slwb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slwb_pkg::t_dp_status i_status,
    output slwb_pkg::t_dp_cmd   o_cmd
);

    slwb_pkg::t_state                  r_state, n_state;
    logic [slwb_pkg::STEP_W-1:0]       r_step_cnt, n_step_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= slwb_pkg::ST_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step_cnt = '0;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            slwb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.need_mod ? slwb_pkg::ST_MOD : slwb_pkg::ST_UPD;
                end
            end
            slwb_pkg::ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step_cnt     = r_step_cnt + 1'b1;
                if (r_step_cnt == slwb_pkg::STEP_W'(slwb_pkg::DIV_STEPS - 1)) begin
                    n_state = slwb_pkg::ST_UPD;
                end
            end
            slwb_pkg::ST_UPD: begin
                // results may be a pair of words, so wait for an empty buffer
                if (i_status.out_empty) begin
                    o_cmd.update = 1'b1;
                    n_state      = slwb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slwb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/slwb_dp.sv =====
`timescale 1ns / 1ps

module slwb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slwb_pkg::t_in_word            i_in,
    input  logic [slwb_pkg::COL_W-1:0]    i_max_width,
    input  logic [slwb_pkg::TAB_W-1:0]    i_tab_width,
    input  slwb_pkg::t_dp_cmd             i_cmd,
    output slwb_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output slwb_pkg::t_out_word           o_out
);

    localparam int COL_W = slwb_pkg::COL_W;
    localparam int POS_W = slwb_pkg::POS_W;
    localparam int CNT_W = slwb_pkg::CNT_W;
    localparam int TAB_W = slwb_pkg::TAB_W;

    // latched word
    logic [7:0]       r_char;
    logic             r_last;

    // line state
    logic [POS_W-1:0] r_char_pos,   n_char_pos;
    logic [COL_W-1:0] r_total_cols, n_total_cols;
    logic [COL_W-1:0] r_row_cols,   n_row_cols;
    logic [POS_W-1:0] r_brk_pos,    n_brk_pos;
    logic [COL_W-1:0] r_brk_col,    n_brk_col;
    logic             r_pend_space, n_pend_space;
    logic             r_space_seen, n_space_seen;
    logic             r_pend_close, n_pend_close;
    logic [CNT_W-1:0] r_brk_cnt,    n_brk_cnt;

    // remainder unit
    logic [COL_W-1:0] r_div_q;
    logic [TAB_W-1:0] r_rem;
    logic [TAB_W:0]   rem_trial;
    logic [TAB_W-1:0] n_rem;

    // result buffer
    slwb_pkg::t_out_word r_out0, r_out1, n_out0, n_out1;
    logic [1:0]          r_out_cnt, n_res_cnt;

    logic [TAB_W-1:0] adv;
    logic [COL_W:0]   row_sum, tot_sum;
    logic             is_tab, out_pop;

    assign o_status.need_mod  = (i_in.char_code == slwb_pkg::CH_TAB) && (i_tab_width != '0);
    assign o_status.out_empty = (r_out_cnt == 2'd0);

    assign o_out_valid = (r_out_cnt != 2'd0);
    assign o_out       = r_out0;
    assign out_pop     = o_out_valid && i_out_ready;

    // restoring remainder step
    always_comb begin
        rem_trial = {r_rem, r_div_q[COL_W-1]};
        if (rem_trial >= {1'b0, i_tab_width}) begin
            n_rem = TAB_W'(rem_trial - {1'b0, i_tab_width});
        end else begin
            n_rem = rem_trial[TAB_W-1:0];
        end
    end

    always_comb begin
        n_char_pos   = r_char_pos;
        n_brk_pos    = r_brk_pos;
        n_brk_col    = r_brk_col;
        n_pend_space = r_pend_space;
        n_space_seen = r_space_seen;
        n_pend_close = r_pend_close;
        n_brk_cnt    = r_brk_cnt;
        n_out0       = '0;
        n_out1       = '0;
        n_res_cnt    = 2'd0;
        is_tab       = (r_char == slwb_pkg::CH_TAB);

        // take the break point left by the previous character
        if (r_pend_space) begin
            n_brk_pos    = r_char_pos;
            n_brk_col    = r_total_cols;
            n_pend_space = 1'b0;
            n_space_seen = 1'b1;
        end else if (r_pend_close && !r_space_seen) begin
            n_brk_pos    = r_char_pos;
            n_brk_col    = r_total_cols;
            n_pend_close = 1'b0;
        end

        if (is_tab) begin
            adv = (i_tab_width != '0) ? TAB_W'(i_tab_width - r_rem) : '0;
        end else begin
            adv = TAB_W'(1);
        end
        row_sum      = {1'b0, r_row_cols} + (COL_W+1)'(adv);
        tot_sum      = {1'b0, r_total_cols} + (COL_W+1)'(adv);
        n_row_cols   = row_sum[COL_W] ? '1 : row_sum[COL_W-1:0];
        n_total_cols = tot_sum[COL_W] ? '1 : tot_sum[COL_W-1:0];

        if (is_tab || r_char == slwb_pkg::CH_SPACE) begin
            n_pend_space = 1'b1;
        end else if (!n_space_seen && (r_char == slwb_pkg::CH_RPAR ||
                                       r_char == slwb_pkg::CH_RBRC)) begin
            n_pend_close = 1'b1;
        end

        if (n_row_cols >= i_max_width) begin
            // forced break when nothing is remembered
            if (n_brk_pos == '0) begin
                n_brk_pos = r_char_pos;
                n_brk_col = n_total_cols;
            end
            n_out0.result_kind  = slwb_pkg::KIND_BREAK;
            n_out0.result_value = COL_W'(n_brk_pos);
            n_out0.break_number = r_brk_cnt;
            n_out0.run_end      = !r_last;
            n_res_cnt           = 2'd1;
            if (r_brk_cnt != CNT_W'(slwb_pkg::CNT_MAX)) begin
                n_brk_cnt = r_brk_cnt + 1'b1;
            end
            n_row_cols   = n_total_cols - n_brk_col;
            n_brk_pos    = '0;
            n_pend_space = 1'b0;
            n_space_seen = 1'b0;
        end

        if (r_last) begin
            if (n_res_cnt == 2'd1) begin
                n_out1.result_kind  = slwb_pkg::KIND_TOTAL;
                n_out1.result_value = n_total_cols;
                n_out1.break_number = n_brk_cnt;
                n_out1.run_end      = 1'b1;
                n_res_cnt           = 2'd2;
            end else begin
                n_out0.result_kind  = slwb_pkg::KIND_TOTAL;
                n_out0.result_value = n_total_cols;
                n_out0.break_number = n_brk_cnt;
                n_out0.run_end      = 1'b1;
                n_res_cnt           = 2'd1;
            end
            n_char_pos   = '0;
            n_total_cols = '0;
            n_row_cols   = '0;
            n_brk_pos    = '0;
            n_brk_col    = '0;
            n_pend_space = 1'b0;
            n_space_seen = 1'b0;
            n_pend_close = 1'b0;
            n_brk_cnt    = '0;
        end else if (r_char_pos < POS_W'(slwb_pkg::POS_LIMIT)) begin
            n_char_pos = r_char_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char  <= i_in.char_code;
            r_last  <= i_in.last_char;
            r_div_q <= r_total_cols;
            r_rem   <= '0;
        end else if (i_cmd.mod_step) begin
            r_div_q <= {r_div_q[COL_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_pos   <= '0;
            r_total_cols <= '0;
            r_row_cols   <= '0;
            r_brk_pos    <= '0;
            r_brk_col    <= '0;
            r_pend_space <= 1'b0;
            r_space_seen <= 1'b0;
            r_pend_close <= 1'b0;
            r_brk_cnt    <= '0;
        end else if (i_cmd.update) begin
            r_char_pos   <= n_char_pos;
            r_total_cols <= n_total_cols;
            r_row_cols   <= n_row_cols;
            r_brk_pos    <= n_brk_pos;
            r_brk_col    <= n_brk_col;
            r_pend_space <= n_pend_space;
            r_space_seen <= n_space_seen;
            r_pend_close <= n_pend_close;
            r_brk_cnt    <= n_brk_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (i_cmd.update) begin
            r_out_cnt <= n_res_cnt;
        end else if (out_pop) begin
            r_out_cnt <= r_out_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out0 <= n_out0;
            r_out1 <= n_out1;
        end else if (out_pop) begin
            r_out0 <= r_out1;
        end
    end

    a_out_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_update_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> r_out_cnt == 2'd0)
        else $error("results loaded over pending words");

    a_row_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_cols <= r_total_cols)
        else $error("row width exceeds line width");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_last |=> r_char_pos == '0 && r_brk_cnt == '0)
        else $error("line state not cleared after last character");

endmodule
